// ===== design/lssc_pkg.sv =====
// ----------------------------------------------------------------------------
// lssc_pkg
// shared types and constants of the line slope steering controller
// ----------------------------------------------------------------------------
package lssc_pkg;

    typedef struct packed {
        logic [8:0] start_x;
        logic [7:0] start_y;
        logic [8:0] end_x;
        logic [7:0] end_y;
        logic       last_vector;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] steer_command;
        logic [6:0]         drive_speed;
    } out_item_t;

    typedef struct packed {
        logic [15:0] steer_gain_q8;
        logic [8:0]  min_vector_length;
        logic [15:0] min_slope_q8;
        logic [14:0] angle_limit;
        logic [6:0]  speed_pct;
    } cfg_t;

    localparam logic [2:0] CFG_GAIN      = 3'd0;
    localparam logic [2:0] CFG_MIN_LEN   = 3'd1;
    localparam logic [2:0] CFG_MIN_SLOPE = 3'd2;
    localparam logic [2:0] CFG_LIMIT     = 3'd3;
    localparam logic [2:0] CFG_SPEED     = 3'd4;

    // datapath commands
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,      // capture item, form dx dy and tests
        CMD_SQRT_INIT,
        CMD_SQRT_STEP,
        CMD_DIV_INIT,  // term division
        CMD_DIV_STEP,
        CMD_ACCUM,
        CMD_MEAN_INIT, // mean division
        CMD_MUL1,
        CMD_MUL2,
        CMD_RESULT,
        CMD_CLEAR
    } cmd_t;

    typedef struct packed {
        logic keep;      // vector passes all tests and frame not full
        logic last;
    } status_t;

endpackage

// ===== design/lssc_datapath.sv =====
// ----------------------------------------------------------------------------
// lssc_datapath
// arithmetic: dx dy tests, serial square root, serial divider, accumulators
// ----------------------------------------------------------------------------
module lssc_datapath #(
    parameter int MAX_VECTORS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lssc_pkg::cmd_t    cmd,
    input  lssc_pkg::in_item_t item,
    input  lssc_pkg::cfg_t    cfg,
    output lssc_pkg::status_t status,
    output lssc_pkg::out_item_t result
);
    import lssc_pkg::*;

    logic [9:0]  adx_reg, adx_next;
    logic [7:0]  ady_reg, ady_next;
    logic        neg_reg, neg_next;
    logic        keep_reg, keep_next;
    logic        last_reg, last_next;
    logic [8:0]  count_reg, count_next;

    // square root: radicand below 2^27, final root up to 14 bits,
    // partial root kept at radicand width
    logic [26:0] rad_reg, rad_next;
    logic [26:0] root_reg, root_next;
    logic [26:0] rbit_reg, rbit_next;

    // shared restoring divider: dividend up to 48 bits
    logic [47:0] quo_reg, quo_next;
    logic [24:0] rem_reg, rem_next;
    logic [23:0] dvs_reg, dvs_next;

    logic signed [47:0] wsum_reg, wsum_next;
    logic [23:0] lsum_reg, lsum_next;
    logic [39:0] prod_reg, prod_next;
    logic        rneg_reg, rneg_next;
    out_item_t   res_reg, res_next;

    logic signed [9:0] dx;
    logic signed [8:0] dy;
    logic [9:0]  adx_in;
    logic [7:0]  ady_in;
    logic [19:0] sq;
    logic [17:0] minsq;
    logic [24:0] slope_l, slope_r;
    logic [26:0] trial;
    logic [24:0] rshift;
    logic [47:0] mag, ang;
    logic [47:0] wabs;

    always_comb
    begin
        dx = $signed({1'b0, item.end_x}) - $signed({1'b0, item.start_x});
        dy = $signed({1'b0, item.end_y}) - $signed({1'b0, item.start_y});
        adx_in = dx[9] ? 10'(-dx) : 10'(dx);
        ady_in = dy[8] ? 8'(-dy) : 8'(dy);
        sq = 20'(adx_in) * 20'(adx_in) + 20'(ady_in) * 20'(ady_in);
        minsq = 18'(cfg.min_vector_length) * 18'(cfg.min_vector_length);
        slope_l = {7'd0, adx_in, 8'd0};
        slope_r = 25'(cfg.min_slope_q8) * 25'(ady_in);
        trial = root_reg + rbit_reg;
        rshift = {rem_reg[23:0], quo_reg[47]};
        mag = {quo_reg[47:0]};
        wabs = wsum_reg[47] ? 48'(-wsum_reg) : 48'(wsum_reg);
        ang = 48'(prod_reg) * 48'd100;
    end

    always_comb
    begin
        adx_next = adx_reg; ady_next = ady_reg; neg_next = neg_reg;
        keep_next = keep_reg; last_next = last_reg; count_next = count_reg;
        rad_next = rad_reg; root_next = root_reg; rbit_next = rbit_reg;
        quo_next = quo_reg; rem_next = rem_reg; dvs_next = dvs_reg;
        wsum_next = wsum_reg; lsum_next = lsum_reg; prod_next = prod_reg;
        rneg_next = rneg_reg; res_next = res_reg;
        case (cmd)
            CMD_LOAD:
            begin
                adx_next = adx_in;
                ady_next = ady_in;
                neg_next = (dx[9] != dy[8]);
                last_next = item.last_vector;
                keep_next = 1'b0;
                if (count_reg < 9'(MAX_VECTORS))
                begin
                    count_next = count_reg + 9'd1;
                    keep_next = (ady_in != 8'd0) && ({2'd0, minsq} < sq)
                        && (slope_l > slope_r);
                end
                rad_next = {sq[18:0], 8'd0};
            end
            CMD_SQRT_INIT:
            begin
                root_next = '0;
                rbit_next = 27'd1 << 26;
            end
            CMD_SQRT_STEP:
            begin
                if (rad_reg >= trial)
                begin
                    rad_next = rad_reg - trial;
                    root_next = (root_reg >> 1) + rbit_reg;
                end
                else
                    root_next = root_reg >> 1;
                rbit_next = rbit_reg >> 2;
            end
            CMD_DIV_INIT:
            begin
                quo_next = {16'd0, 24'(adx_reg) * 24'(root_reg[13:0]), 8'd0};
                rem_next = '0;
                dvs_next = {16'd0, ady_reg};
            end
            CMD_MEAN_INIT:
            begin
                quo_next = wabs;
                rem_next = '0;
                dvs_next = lsum_reg;
                rneg_next = wsum_reg[47];
            end
            CMD_DIV_STEP:
            begin
                if (rshift >= {1'b0, dvs_reg})
                begin
                    rem_next = rshift - {1'b0, dvs_reg};
                    quo_next = {quo_reg[46:0], 1'b1};
                end
                else
                begin
                    rem_next = rshift;
                    quo_next = {quo_reg[46:0], 1'b0};
                end
            end
            CMD_ACCUM:
            begin
                wsum_next = neg_reg ? wsum_reg - $signed(mag) : wsum_reg + $signed(mag);
                lsum_next = lsum_reg + 24'(root_reg[13:0]);
            end
            CMD_MUL1:
                // mean fits 24 bits: a length-weighted mean is no larger than the largest slope term
                prod_next = 40'(quo_reg[23:0]) * 40'(cfg.steer_gain_q8);
            CMD_MUL2:
                prod_next = 40'(ang >> 16);
            CMD_RESULT:
            begin
                res_next.drive_speed = cfg.speed_pct;
                if (lsum_reg == '0)
                    res_next.steer_command = '0;
                else if (prod_reg > 40'(cfg.angle_limit))
                    res_next.steer_command = rneg_reg ? 16'(cfg.angle_limit)
                                                      : -16'(cfg.angle_limit);
                else
                    res_next.steer_command = rneg_reg ? 16'(prod_reg) : -16'(prod_reg);
            end
            CMD_CLEAR:
            begin
                wsum_next = '0; lsum_next = '0; count_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsum_reg <= '0; lsum_reg <= '0; count_reg <= '0;
            keep_reg <= 1'b0; last_reg <= 1'b0;
        end
        else
        begin
            wsum_reg <= wsum_next; lsum_reg <= lsum_next; count_reg <= count_next;
            keep_reg <= keep_next; last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        adx_reg <= adx_next; ady_reg <= ady_next; neg_reg <= neg_next;
        rad_reg <= rad_next; root_reg <= root_next; rbit_reg <= rbit_next;
        quo_reg <= quo_next; rem_reg <= rem_next; dvs_reg <= dvs_next;
        prod_reg <= prod_next; rneg_reg <= rneg_next; res_reg <= res_next;
    end

    assign status = '{keep: keep_reg, last: last_reg};
    assign result = res_reg;
endmodule

// ===== design/lssc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lssc_ctrl
// sequencer: handshakes and step order of the datapath
// ----------------------------------------------------------------------------
module lssc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  lssc_pkg::status_t status,
    output lssc_pkg::cmd_t    cmd
);
    import lssc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_TEST, S_SQRT, S_TDIV, S_ACC, S_FIN, S_MDIV, S_MUL1, S_MUL2,
        S_RES, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        ov_next = ov_reg;
        cmd = CMD_NONE;
        case (state_reg)
            S_IDLE:
                if (in_valid && !ov_reg)
                begin
                    cmd = CMD_LOAD;
                    state_next = S_TEST;
                end
            S_TEST:
                if (status.keep)
                begin
                    cmd = CMD_SQRT_INIT;
                    cnt_next = 6'd13;
                    state_next = S_SQRT;
                end
                else
                    state_next = S_FIN;
            S_SQRT:
            begin
                cmd = CMD_SQRT_STEP;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                    state_next = S_TDIV;
            end
            S_TDIV:
            begin
                cmd = CMD_DIV_INIT;
                cnt_next = 6'd47;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd = CMD_DIV_STEP;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (cnt_reg == 6'd63)
                    cmd = CMD_NONE;
                if (status.keep && cnt_reg != 6'd62)
                begin
                    cmd = CMD_ACCUM;
                    cnt_next = 6'd62;
                end
                else if (!status.last)
                    state_next = S_IDLE;
                else
                begin
                    cmd = CMD_MEAN_INIT;
                    cnt_next = 6'd47;
                    state_next = S_MDIV;
                end
            end
            S_MDIV:
            begin
                cmd = CMD_DIV_STEP;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                    state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd = CMD_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd = CMD_MUL2;
                state_next = S_RES;
            end
            S_RES:
            begin
                cmd = CMD_RESULT;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd = CMD_CLEAR;
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            ov_reg <= ov_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
endmodule

// ===== design/line_slope_steering_controller.sv =====
// ----------------------------------------------------------------------------
// line_slope_steering_controller
// length-weighted line slope to steering angle and drive speed
// ----------------------------------------------------------------------------
// One vector is taken at a time. A kept vector passes through the 14-step
// square root and the 48-step shared restoring divider; a rejected vector
// skips both. The frame's last vector adds 48 divider steps for the mean,
// the MUL1 and MUL2 multiply steps, a result step and a clear step. The result
// waits in an output register; no new vector is taken until it is delivered.
module line_slope_steering_controller #(
    parameter int MAX_VECTORS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  lssc_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output lssc_pkg::out_item_t  out_data,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import lssc_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;

    // configuration registers, reset to the defaults
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.steer_gain_q8     <= 16'd16896;
            cfg_reg.min_vector_length <= 9'd35;
            cfg_reg.min_slope_q8      <= 16'd51;
            cfg_reg.angle_limit       <= 15'd8000;
            cfg_reg.speed_pct         <= 7'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN:      cfg_reg.steer_gain_q8     <= cfg_data;
                CFG_MIN_LEN:   cfg_reg.min_vector_length <= cfg_data[8:0];
                CFG_MIN_SLOPE: cfg_reg.min_slope_q8      <= cfg_data;
                CFG_LIMIT:     cfg_reg.angle_limit       <= cfg_data[14:0];
                CFG_SPEED:     cfg_reg.speed_pct         <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    lssc_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
        .status, .cmd
    );

    lssc_datapath #(.MAX_VECTORS(MAX_VECTORS)) u_dp (
        .clk, .rst_n, .cmd, .item(in_data), .cfg(cfg_reg), .status,
        .result(out_data)
    );
endmodule

// ===== tb/line_slope_steering_controller_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_slope_steering_controller_test
// self-checking bench: line vectors in, steering and speed out
// ----------------------------------------------------------------------------
// A directed table of vectors runs first, then random frames under several
// register settings. An internal predictor tracks the slope and length sums
// and forms the expected steering item on every last vector. Results are
// compared field by field in order; the sender idles in bursts and the
// receiver stalls on its own pattern.
module line_slope_steering_controller_test;
    import lssc_pkg::*;

    localparam int MAX_VEC   = 64;
    localparam int CYC_LIMIT = 2000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = CFG_GAIN;
    logic [15:0] cfg_data = '0;

    line_slope_steering_controller #(.MAX_VECTORS(MAX_VEC)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of the registers and accumulators
    cfg_t                pcfg;
    logic signed [63:0]  slope_acc;
    logic [31:0]         len_acc;
    int unsigned         frame_vecs;

    out_item_t steer_queue[$];
    int        errors = 0;
    int        results_seen = 0;
    int        frames_sent = 0;
    longint    cycles = 0;

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d (result %0d)",
                 what, $signed(got), $signed(want), results_seen);
        errors++;
    endtask

    function automatic logic [31:0] isqrt(input logic [31:0] v);
        logic [31:0] r;
        logic [31:0] b;
        r = 0;
        b = 32'h4000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void pred_reset();
        pcfg = '{steer_gain_q8: 16'd16896, min_vector_length: 9'd35,
                 min_slope_q8: 16'd51, angle_limit: 15'd8000, speed_pct: 7'd100};
        slope_acc = 0;
        len_acc = 0;
        frame_vecs = 0;
    endfunction

    // update sums for one vector; returns 1 and fills res on a frame end
    function automatic bit steer_predict(input in_item_t v, output out_item_t res);
        int          dx;
        int          dy;
        longint      adx;
        longint      ady;
        longint      sq;
        longint      ln;
        longint      mag;
        longint      w;
        longint      mean;
        longint      ang;
        bit          neg;
        dx  = int'(v.end_x) - int'(v.start_x);
        dy  = int'(v.end_y) - int'(v.start_y);
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        sq  = adx * adx + ady * ady;
        res = '0;
        if (frame_vecs < MAX_VEC)
        begin
            frame_vecs++;
            if (ady != 0 && sq > longint'(pcfg.min_vector_length) * pcfg.min_vector_length
                && adx * 256 > longint'(pcfg.min_slope_q8) * ady)
            begin
                ln  = isqrt(32'(sq << 8));
                mag = (adx * 256 * ln) / ady;
                slope_acc += ((dx < 0) != (dy < 0)) ? -mag : mag;
                len_acc += 32'(ln);
            end
        end
        if (!v.last_vector)
            return 0;
        ang = 0;
        neg = 0;
        if (len_acc != 0)
        begin
            neg  = slope_acc < 0;
            w    = neg ? -slope_acc : slope_acc;
            mean = w / longint'(len_acc);
            ang  = (mean * pcfg.steer_gain_q8 * 100) >>> 16;
            if (ang > pcfg.angle_limit)
                ang = pcfg.angle_limit;
        end
        res.steer_command = neg ? 16'(ang) : 16'(-ang);
        res.drive_speed   = pcfg.speed_pct;
        slope_acc = 0;
        len_acc = 0;
        frame_vecs = 0;
        return 1;
    endfunction

    // send one vector with burst idling; on a last vector queue the frame's expected result
    // valid stays high after acceptance until the next gap or settle
    task automatic send_vector(input in_item_t v);
        out_item_t r;
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (steer_predict(v, r))
        begin
            steer_queue.push_back(r);
            frames_sent++;
        end
    endtask

    // write enable is dropped by the caller after the last write
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_GAIN:      pcfg.steer_gain_q8     = val;
            CFG_MIN_LEN:   pcfg.min_vector_length = val[8:0];
            CFG_MIN_SLOPE: pcfg.min_slope_q8      = val;
            CFG_LIMIT:     pcfg.angle_limit       = val[14:0];
            CFG_SPEED:     pcfg.speed_pct         = val[6:0];
            default: ;
        endcase
    endtask

    // drain expectations, then the block's internal tail
    task automatic settle();
        in_valid <= 1'b0;
        while (steer_queue.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    function automatic in_item_t rand_vector(input bit last);
        in_item_t v;
        v.start_x = 9'($urandom_range(0, 319));
        v.end_x   = 9'($urandom_range(0, 319));
        v.start_y = 8'($urandom_range(0, 255));
        v.end_y   = ($urandom_range(0, 9) == 0) ? v.start_y : 8'($urandom_range(0, 255));
        v.last_vector = last;
        return v;
    endfunction

    // receiver stall pattern: quiet stretches and heavy stretches
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (((cycles >> 9) & 1) == 0)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 2) == 0);
    end

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (steer_queue.size() == 0)
            begin
                $display("unexpected result: steer %0d speed %0d",
                         out_data.steer_command, out_data.drive_speed);
                errors++;
            end
            else
            begin
                if (out_data.steer_command !== steer_queue[0].steer_command)
                    report("steer_command", 32'(out_data.steer_command),
                           32'(steer_queue[0].steer_command));
                if (out_data.drive_speed !== steer_queue[0].drive_speed)
                    report("drive_speed", 32'(out_data.drive_speed),
                           32'(steer_queue[0].drive_speed));
                void'(steer_queue.pop_front());
            end
            results_seen++;
        end
    end

    // timeout
    always @(posedge clk)
    begin
        if (cycles > CYC_LIMIT)
        begin
            $display("timeout with %0d results outstanding", steer_queue.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // directed vectors: sx sy ex ey last, expected steer/speed when obvious
    typedef struct {
        in_item_t  v;
        bit        known;
        out_item_t want;
    } vec_row_t;

    vec_row_t dir_rows[] = '{
        '{'{9'd0, 8'd0, 9'd0, 8'd0, 1'b1}, 1, '{16'sd0, 7'd100}},
        '{'{9'd0, 8'd0, 9'd319, 8'd0, 1'b1}, 1, '{16'sd0, 7'd100}},
        '{'{9'd0, 8'd0, 9'd319, 8'd255, 1'b0}, 0, '0},
        '{'{9'd319, 8'd255, 9'd0, 8'd0, 1'b1}, 0, '0},
        '{'{9'd0, 8'd255, 9'd319, 8'd0, 1'b1}, 0, '0},
        '{'{9'd319, 8'd0, 9'd0, 8'd255, 1'b1}, 0, '0},
        '{'{9'd100, 8'd0, 9'd100, 8'd200, 1'b1}, 1, '{16'sd0, 7'd100}},
        '{'{9'd10, 8'd10, 9'd15, 8'd15, 1'b1}, 1, '{16'sd0, 7'd100}},
        '{'{9'd0, 8'd0, 9'd200, 8'd5, 1'b0}, 0, '0},
        '{'{9'd0, 8'd0, 9'd200, 8'd5, 1'b1}, 1, '{-16'sd8000, 7'd100}},
        '{'{9'd200, 8'd0, 9'd0, 8'd5, 1'b1}, 1, '{16'sd8000, 7'd100}},
        '{'{9'd0, 8'd0, 9'd60, 8'd40, 1'b0}, 0, '0},
        '{'{9'd60, 8'd0, 9'd0, 8'd40, 1'b1}, 0, '0},
        '{'{9'd256, 8'd128, 9'd0, 8'd127, 1'b1}, 0, '0},
        '{'{9'd511, 8'd255, 9'd511, 8'd0, 1'b1}, 0, '0},
        '{'{9'd0, 8'd255, 9'd511, 8'd255, 1'b1}, 0, '0}
    };

    initial
    begin
        vec_row_t   row;
        in_item_t   v;
        int         nvec;
        int         sent;
        int         fcount;
        pred_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under reset settings
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_vector(row.v);
            if (row.known && row.v.last_vector
                && steer_queue[steer_queue.size() - 1] !== row.want)
            begin
                $display("directed row %0d: predictor disagrees with table", i);
                errors++;
            end
        end
        // frame overflow: more than the vector cap, then the last mark
        for (int k = 0; k < MAX_VEC + 6; k++)
        begin
            v = '{9'd0, 8'd0, 9'd300, 8'd100, 1'b0};
            if (k >= MAX_VEC)
                v = '{9'd300, 8'd0, 9'd0, 8'd100, 1'b0};
            send_vector(v);
        end
        send_vector('{9'd0, 8'd0, 9'd0, 8'd0, 1'b1});
        sent = 16 + MAX_VEC + 7;
        settle();

        // random frames over a sweep of settings, extremes included
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: begin write_reg(CFG_GAIN, 16'hFFFF); write_reg(CFG_MIN_LEN, 16'd0);
                         write_reg(CFG_MIN_SLOPE, 16'd0); write_reg(CFG_LIMIT, 16'h7FFF);
                         write_reg(CFG_SPEED, 16'h7F); end
                1: begin write_reg(CFG_GAIN, 16'd0); write_reg(CFG_SPEED, 16'd0); end
                2: begin write_reg(CFG_GAIN, 16'd16896); write_reg(CFG_MIN_LEN, 16'd511);
                         write_reg(CFG_LIMIT, 16'd18000); end
                3: begin write_reg(CFG_MIN_LEN, 16'd35); write_reg(CFG_MIN_SLOPE, 16'hFFFF);
                         write_reg(CFG_LIMIT, 16'd0); end
                default:
                begin
                    write_reg(CFG_GAIN, 16'($urandom_range(0, 65535)));
                    write_reg(CFG_MIN_LEN, 16'($urandom_range(0, 120)));
                    write_reg(CFG_MIN_SLOPE, 16'($urandom_range(0, 1024)));
                    write_reg(CFG_LIMIT, 16'($urandom_range(0, 18000)));
                    write_reg(CFG_SPEED, 16'($urandom_range(0, 100)));
                end
            endcase
            cfg_we <= 1'b0;
            fcount = (phase < 4) ? 10 : 22;
            for (int f = 0; f < fcount; f++)
            begin
                nvec = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                                    : $urandom_range(1, 12);
                for (int k = 0; k < nvec; k++)
                    send_vector(rand_vector(k == nvec - 1));
                sent += nvec;
            end
            settle();
        end

        $display("%0d vectors in %0d frames, %0d steering results checked",
                 sent, frames_sent, results_seen);
        $display("covered: reset settings, register extremes, empty and full frames");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
